// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ----- sv/rvde_pkg.sv -----
`default_nettype none
package rvde_pkg;

  localparam int unsigned XLEN = 32;

  typedef enum logic [6:0] {
    OPC_REG    = 7'h33,
    OPC_IMM    = 7'h13,
    OPC_LOAD   = 7'h03,
    OPC_JALR   = 7'h67,
    OPC_STORE  = 7'h23,
    OPC_BRANCH = 7'h63,
    OPC_LUI    = 7'h37,
    OPC_AUIPC  = 7'h17,
    OPC_JAL    = 7'h6f
  } opcode_e;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_SLL, ALU_SRL, ALU_SRA,
    ALU_SLT, ALU_MUL, ALU_DIV, ALU_REM, ALU_LUI, ALU_AUIPC
  } alu_op_e;

  localparam logic [2:0] BR_EQ = 3'd0;
  localparam logic [2:0] BR_NE = 3'd1;
  localparam logic [2:0] BR_LT = 3'd4;
  localparam logic [2:0] BR_GE = 3'd5;

  localparam logic [6:0] F7_ALT = 7'h20;
  localparam logic [6:0] F7_MUL = 7'h01;

  // Classified instruction handed from decode to execute
  typedef struct packed {
    alu_op_e     op;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] imm;
    logic [31:0] pc;
    logic [31:0] store_data;
    logic [4:0]  dest_reg;
    logic [2:0]  funct3;
    logic [2:0]  access_size;
    logic        write_back;
    logic        mem_load;
    logic        mem_store;
    logic        cond_br;
    logic        is_jump;
    logic        is_jalr;
  } dec_t;

  typedef struct packed {
    logic [31:0] result;
    logic [4:0]  dest_reg;
    logic        write_back;
    logic        mem_load;
    logic        mem_store;
    logic [2:0]  access_size;
    logic [31:0] store_data;
    logic        cond_br;
    logic        br_taken;
    logic        redirect;
    logic [31:0] next_pc;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/rvde_decode.sv -----
`default_nettype none
// Front end: decode the word, build immediates and pick operands
module rvde_decode (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [31:0] instruction_i,
  input  wire logic [31:0] fetch_pc_i,
  input  wire logic [31:0] rs1_value_i,
  input  wire logic [31:0] rs2_value_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output rvde_pkg::dec_t   dec_o
);
  import rvde_pkg::*;

  logic   [6:0] opc, f7;
  logic   [2:0] f3;
  logic         use_imm;
  dec_t         dec_d, dec_q;
  logic         valid_q;

  assign opc = instruction_i[6:0];
  assign f3  = instruction_i[14:12];
  assign f7  = instruction_i[31:25];

  // Classify the opcode
  always_comb begin
    dec_d = '0;
    use_imm = 1'b0;
    dec_d.op = ALU_ADD;
    dec_d.pc = fetch_pc_i;
    dec_d.store_data = rs2_value_i;
    dec_d.dest_reg = instruction_i[11:7];
    dec_d.funct3 = f3;
    unique case (opc)
      OPC_REG: begin
        dec_d.write_back = 1'b1;
        case (f3)
          3'd1: dec_d.op = ALU_SLL;
          3'd2: dec_d.op = ALU_SLT;
          3'd4: dec_d.op = ALU_XOR;
          3'd5: dec_d.op = (f7 & F7_ALT) != 7'd0 ? ALU_SRA : ALU_SRL;
          3'd6: dec_d.op = ALU_OR;
          3'd7: dec_d.op = ALU_AND;
          3'd0: dec_d.op = (f7 & F7_ALT) != 7'd0 ? ALU_SUB : ALU_ADD;
          default: dec_d.op = ALU_ADD;
        endcase
        if (f7 == F7_MUL) begin
          if (f3 == 3'd0) dec_d.op = ALU_MUL;
          else if (f3 == 3'd4) dec_d.op = ALU_DIV;
          else if (f3 == 3'd6) dec_d.op = ALU_REM;
        end
      end
      OPC_IMM, OPC_LOAD, OPC_JALR: begin
        dec_d.write_back = 1'b1;
        use_imm = 1'b1;
        dec_d.imm = {{20{instruction_i[31]}}, instruction_i[31:20]};
        if (opc == OPC_LOAD) begin
          dec_d.mem_load = 1'b1;
          dec_d.access_size = f3;
        end else if (opc == OPC_JALR) begin
          dec_d.is_jump = 1'b1;
          dec_d.is_jalr = 1'b1;
        end else begin
          case (f3)
            3'd1: dec_d.op = ALU_SLL;
            3'd4: dec_d.op = ALU_XOR;
            3'd6: dec_d.op = ALU_OR;
            3'd7: dec_d.op = ALU_AND;
            default: dec_d.op = ALU_ADD;
          endcase
        end
      end
      OPC_STORE: begin
        dec_d.mem_store = 1'b1;
        use_imm = 1'b1;
        dec_d.imm = {{20{instruction_i[31]}}, instruction_i[31:25], instruction_i[11:7]};
        dec_d.access_size = f3;
      end
      OPC_BRANCH: begin
        dec_d.cond_br = 1'b1;
        dec_d.imm = {{19{instruction_i[31]}}, instruction_i[31], instruction_i[7],
                     instruction_i[30:25], instruction_i[11:8], 1'b0};
        dec_d.op = alu_op_e'({1'b0, f3});
      end
      OPC_LUI, OPC_AUIPC: begin
        dec_d.write_back = 1'b1;
        use_imm = 1'b1;
        dec_d.imm = {instruction_i[31:12], 12'd0};
        dec_d.op = (opc == OPC_LUI) ? ALU_LUI : ALU_AUIPC;
      end
      OPC_JAL: begin
        dec_d.write_back = 1'b1;
        dec_d.is_jump = 1'b1;
        dec_d.imm = {{11{instruction_i[31]}}, instruction_i[31], instruction_i[19:12],
                     instruction_i[20], instruction_i[30:21], 1'b0};
      end
      default: ;
    endcase
    dec_d.op_a = rs1_value_i;
    dec_d.op_b = use_imm ? dec_d.imm : rs2_value_i;
  end

  // Output register, advance when empty or taken
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign dec_o   = dec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end
endmodule
`default_nettype wire

// ----- sv/rvde_queue.sv -----
`default_nettype none
// Two-entry queue between decode and execute
module rvde_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire rvde_pkg::dec_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output rvde_pkg::dec_t      data_o
);
  import rvde_pkg::*;

  `include "assert_macros.svh"

  dec_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'd2, "queue count out of range")
  `ASSERT_CLK(a_ptr_match, clk_i, rst_ni, (cnt_q == 2'd1) == (wr_q != rd_q),
              "queue pointers disagree with count")
  `ASSERT_CLK(a_full_hold, clk_i, rst_ni, cnt_q == 2'd2 && !ready_i |=> cnt_q == 2'd2,
              "full queue lost an entry")
endmodule
`default_nettype wire

// ----- sv/rvde_divider.sv -----
`default_nettype none
// Pipelined unsigned divider, one quotient bit per stage, tag carried along
module rvde_divider #(
  parameter int unsigned Width = rvde_pkg::XLEN,
  parameter int unsigned TagW  = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  input  wire logic [TagW-1:0]  tag_i,
  output logic      [Width-1:0] quot_o,
  output logic      [Width-1:0] rem_o,
  output logic      [TagW-1:0]  tag_o
);
  logic [Width-1:0] q_q [Width+1];
  logic [Width-1:0] r_q [Width+1];
  logic [Width-1:0] d_q [Width+1];
  logic [TagW-1:0]  t_q [Width+1];

  always_comb begin
    q_q[0] = dividend_i;
    r_q[0] = '0;
    d_q[0] = divisor_i;
    t_q[0] = tag_i;
  end

  // One restoring step per stage, advance together on enable
  for (genvar s = 0; s < Width; s++) begin : g_stage
    logic [Width:0] trial;
    assign trial = {r_q[s], q_q[s][Width-1]} - {1'b0, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[Width]) begin
          r_q[s+1] <= trial[Width-1:0];
          q_q[s+1] <= {q_q[s][Width-2:0], 1'b1};
        end else begin
          r_q[s+1] <= {r_q[s][Width-2:0], q_q[s][Width-1]};
          q_q[s+1] <= {q_q[s][Width-2:0], 1'b0};
        end
        d_q[s+1] <= d_q[s];
        t_q[s+1] <= t_q[s];
      end
    end
  end

  assign quot_o = q_q[Width];
  assign rem_o  = r_q[Width];
  assign tag_o  = t_q[Width];
endmodule
`default_nettype wire

// ----- sv/rvde_execute.sv -----
`default_nettype none
// Back end: ALU, multiply/divide, branch resolve and next pc, in a fixed-depth pipeline
module rvde_execute (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire rvde_pkg::dec_t dec_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output rvde_pkg::res_t      res_o
);
  import rvde_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned Depth = XLEN + 1;
  localparam int unsigned TagW  = $bits(res_t) + 3;

  // Stage 1: everything but the divide
  res_t        s1_d, s1_q;
  logic        s1_neg_q, s1_div_q, s1_rem_q, s1_mul_q;
  logic [31:0] ua_q, ub_q, mul_q;
  logic        v_q [Depth];
  logic        en, any_v;
  logic [31:0] a, b, alu, sum, ua, ub;
  logic [4:0]  sh;
  logic        lt, taken;
  logic [31:0] prod;

  assign a  = dec_i.op_a;
  assign b  = dec_i.op_b;
  assign sh = b[4:0];
  assign lt = $signed(a) < $signed(b);
  assign sum = a + b;

  always_comb begin
    case (dec_i.op)
      ALU_SUB:   alu = a - b;
      ALU_AND:   alu = a & b;
      ALU_OR:    alu = a | b;
      ALU_XOR:   alu = a ^ b;
      ALU_SLL:   alu = a << sh;
      ALU_SRL:   alu = a >> sh;
      ALU_SRA:   alu = 32'($signed(a) >>> sh);
      ALU_SLT:   alu = {31'd0, lt};
      ALU_LUI:   alu = dec_i.imm;
      ALU_AUIPC: alu = dec_i.pc + dec_i.imm;
      default:   alu = sum;
    endcase
  end

  // Resolve branches and jumps
  always_comb begin
    taken = 1'b0;
    if (dec_i.cond_br) begin
      case (dec_i.funct3)
        BR_EQ:   taken = a == b;
        BR_NE:   taken = a != b;
        BR_LT:   taken = lt;
        BR_GE:   taken = !lt;
        default: taken = 1'b0;
      endcase
    end
    s1_d.result       = dec_i.is_jump ? dec_i.pc + 32'd4 : alu;
    s1_d.dest_reg     = dec_i.dest_reg;
    s1_d.write_back   = dec_i.write_back;
    s1_d.mem_load     = dec_i.mem_load;
    s1_d.mem_store    = dec_i.mem_store;
    s1_d.access_size  = dec_i.access_size;
    s1_d.store_data   = dec_i.store_data;
    s1_d.cond_br      = dec_i.cond_br;
    s1_d.br_taken     = taken;
    s1_d.redirect     = taken || dec_i.is_jump;
    if (dec_i.is_jalr)
      s1_d.next_pc = sum & ~32'd1;
    else if (taken || dec_i.is_jump)
      s1_d.next_pc = dec_i.pc + dec_i.imm;
    else
      s1_d.next_pc = dec_i.pc + 32'd4;
  end

  assign ua   = a[31] ? 32'd0 - a : a;
  assign ub   = b[31] ? 32'd0 - b : b;
  assign prod = a * b;

  // Whole pipe advances when the tail is free
  assign en      = !v_q[Depth-1] || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < Depth; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      ua_q     <= ua;
      ub_q     <= ub;
      mul_q    <= prod;
      s1_mul_q <= dec_i.op == ALU_MUL;
      s1_div_q <= dec_i.op == ALU_DIV;
      s1_rem_q <= dec_i.op == ALU_REM;
      s1_neg_q <= dec_i.op == ALU_REM ? a[31] : a[31] ^ b[31];
    end
  end

  // Stage 2 onward: divider carries the rest of the item
  res_t           s2;
  logic [TagW-1:0] tag_in, tag_out;
  logic [31:0]    q, r, mag, fin;
  res_t           tail;
  logic           t_neg, t_div, t_rem;

  always_comb begin
    s2 = s1_q;
    if (s1_mul_q) s2.result = mul_q;
  end
  assign tag_in = {s2, s1_neg_q, s1_div_q, s1_rem_q};

  rvde_divider #(.Width(XLEN), .TagW(TagW)) u_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (ua_q),
    .divisor_i  (ub_q),
    .tag_i      (tag_in),
    .quot_o     (q),
    .rem_o      (r),
    .tag_o      (tag_out)
  );

  assign {tail, t_neg, t_div, t_rem} = tag_out;
  assign mag = t_rem ? r : q;
  // Zero divisor gives all-ones quotient and remainder = dividend; map to 0
  assign fin = t_neg ? 32'd0 - mag : mag;

  logic zero_q [XLEN+1];
  always_comb zero_q[0] = ub_q == 32'd0;
  for (genvar s = 0; s < XLEN; s++) begin : g_zero
    always_ff @(posedge clk_i) begin
      if (en) zero_q[s+1] <= zero_q[s];
    end
  end

  always_comb begin
    res_o = tail;
    if (t_div || t_rem) res_o.result = zero_q[XLEN] ? 32'd0 : fin;
  end
  assign valid_o = v_q[Depth-1];

  `ASSERT_CLK(a_hold_stall, clk_i, rst_ni, valid_o && !ready_i |=> valid_o,
              "result dropped while stalled")
  `ASSERT_CLK(a_redirect, clk_i, rst_ni,
              valid_o && res_o.br_taken |-> res_o.redirect && res_o.cond_br,
              "taken branch without redirect")
  `ASSERT_NEVER(a_mem_excl, clk_i, rst_ni, valid_o && res_o.mem_load && res_o.mem_store,
                "load and store together")
endmodule
`default_nettype wire

// ----- sv/rv32im_decode_execute.sv -----
`default_nettype none
// Each instruction passes the decode register, one queue slot, then 33 execute stages
// (ALU stage plus 32 divider stages). Throughput: one instruction per cycle while
// m_axis_tready does not stall the pipe; the execute pipe holds a divider of one
// quotient bit per stage, so every op takes the same path length.
// Reset (rst_ni low, asynchronous): all valid flags and queue pointers clear;
// data registers are not reset.
module rv32im_decode_execute (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // [31:0] instruction, [63:32] fetch_pc, [95:64] rs1_value, [127:96] rs2_value
  input  wire logic [127:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [31:0] result, [36:32] dest_reg, [37] write_back, [38] mem_load,
  // [39] mem_store, [42:40] access_size, [74:43] store_data, [75] cond_br,
  // [76] br_taken, [77] redirect, [109:78] next_pc, [111:110] zero
  output logic [111:0]       m_axis_tdata
);
  import rvde_pkg::*;

  dec_t dec, qd;
  res_t res;
  logic dv, dr, qv, qr;

  rvde_decode u_dec (
    .clk_i, .rst_ni,
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .instruction_i (s_axis_tdata[31:0]),
    .fetch_pc_i    (s_axis_tdata[63:32]),
    .rs1_value_i   (s_axis_tdata[95:64]),
    .rs2_value_i   (s_axis_tdata[127:96]),
    .valid_o       (dv),
    .ready_i       (dr),
    .dec_o         (dec)
  );

  rvde_queue u_q (
    .clk_i, .rst_ni,
    .valid_i (dv), .ready_o (dr), .data_i (dec),
    .valid_o (qv), .ready_i (qr), .data_o (qd)
  );

  rvde_execute u_ex (
    .clk_i, .rst_ni,
    .valid_i (qv), .ready_o (qr), .dec_i (qd),
    .valid_o (m_axis_tvalid), .ready_i (m_axis_tready), .res_o (res)
  );

  assign m_axis_tdata = {2'b00, res.next_pc, res.redirect, res.br_taken, res.cond_br,
                         res.store_data, res.access_size, res.mem_store, res.mem_load,
                         res.write_back, res.dest_reg, res.result};
endmodule
`default_nettype wire
